// File: rtl/dso_pkg.sv
// Shared constants, types and the sine table builder for the damped sine oscillator.
package dso_pkg;

  // Default sizes
  localparam int DSO_PHASE_BITS      = 32;
  localparam int DSO_TABLE_ADDR_BITS = 10;
  localparam int DSO_SAMPLE_BITS     = 16;
  localparam int DSO_COUNT_BITS      = 24;

  // Envelope format: unsigned Q1.23
  localparam int          ENV_W    = 24;
  localparam int          ENV_FRAC = 23;
  localparam logic [23:0] ENV_ONE  = 24'd8388608;
  localparam logic [23:0] ENV_MAX  = 24'hFFFFFF;

  // Configuration port
  localparam int          CFG_DATA_W     = 32;
  localparam int          CFG_IDX_W      = 2;
  localparam logic [1:0]  CFG_PHASE_STEP = 2'd0;
  localparam logic [1:0]  CFG_DECAY      = 2'd1;
  localparam logic [1:0]  CFG_COUNT      = 2'd2;

  localparam int          STEP_CFG_W  = 32;
  localparam int          DECAY_CFG_W = 24;
  localparam int          COUNT_CFG_W = 24;

  // Register reset values
  localparam logic [63:0] PHASE_STEP_RST   = 64'd39370534;
  localparam logic [23:0] DECAY_RST        = 24'd8386860;
  localparam logic [63:0] SAMPLE_COUNT_RST = 64'd48000;

  // Queue depths
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Register write strobes
  typedef struct packed {
    logic step_we;
    logic decay_we;
    logic count_we;
  } cfg_wr_t;

  // Per-sample control that travels with the table index
  typedef struct packed {
    logic first;   // restart: envelope starts from 1.0
    logic last;    // final sample of the tone
    logic negate;  // lower half of the wave
    logic mirror;  // read the quarter table backwards
  } cmd_flags_t;

  // Quarter-wave entry i: sin(i*pi/(2*2^tab_bits)) as a Q1.(smp_bits-1) magnitude.
  // Taylor series in Q30, nine terms with fixed divisors (2k)(2k+1); elaboration only.
  function automatic logic [23:0] sine_entry(input int unsigned idx,
                                              input int unsigned tab_bits,
                                              input int unsigned smp_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    longint unsigned smax;
    longint          s;
    x    = (longint'(idx) * HALF_PI_Q30) >> tab_bits;
    x2   = (x * x) >> 30;
    t    = x;
    s    = longint'(x);
    smax = (64'd1 << (smp_bits - 1)) - 64'd1;
    t = ((t * x2) >> 30) / 64'd6;   s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd20;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd42;  s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd72;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd110; s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd156; s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd210; s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd272; s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd342; s = s - longint'(t);
    if (s < 0) s = 0;
    v = ((longint'(s) << (smp_bits - 1)) + (64'd1 << 29)) >> 30;
    if (v > smax) v = smax;
    return 24'(v);
  endfunction

endpackage

// File: rtl/dso_fifo.sv
// Small synchronous queue used between the front, the back and the result port.
module dso_fifo import dso_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

endmodule

// File: rtl/dso_front.sv
// Tick front end: tone control, sample counting and phase accumulation.
module dso_front import dso_pkg::*; #(
  parameter int PHASE_BITS      = DSO_PHASE_BITS,
  parameter int TABLE_ADDR_BITS = DSO_TABLE_ADDR_BITS,
  parameter int COUNT_BITS      = DSO_COUNT_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_wr_t                     cfg_wr,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        in_push,
  input  logic                        in_restart,
  output logic                        in_full,
  output logic                        cmd_push,
  output cmd_flags_t                  cmd_flags,
  output logic [TABLE_ADDR_BITS-1:0]  cmd_index,
  input  logic                        cmd_full
);

  localparam int STEP_W = (PHASE_BITS < STEP_CFG_W) ? PHASE_BITS : STEP_CFG_W;
  localparam int CNT_W  = (COUNT_BITS < COUNT_CFG_W) ? COUNT_BITS : COUNT_CFG_W;

  logic [PHASE_BITS-1:0] step_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] done_r, done_nxt;
  logic                  running_r, running_nxt;

  logic                  accept;
  logic                  eff_run;
  logic [PHASE_BITS-1:0] base_phase;
  logic [COUNT_BITS-1:0] base_done;
  logic [COUNT_BITS-1:0] done_inc;
  logic                  is_last;

  assign in_full = cmd_full;
  assign accept  = in_push & ~cmd_full;

  // classify the tick: restart, running sample or idle
  always_comb begin
    eff_run    = in_restart ? (count_r != '0) : running_r;
    base_phase = in_restart ? '0 : phase_r;
    base_done  = in_restart ? '0 : done_r;
    done_inc   = base_done + COUNT_BITS'(1);
    is_last    = (done_inc >= count_r);

    phase_nxt   = phase_r;
    done_nxt    = done_r;
    running_nxt = running_r;
    if (accept) begin
      phase_nxt   = eff_run ? base_phase + step_r : base_phase;
      done_nxt    = eff_run ? done_inc : base_done;
      running_nxt = eff_run & ~is_last;
    end
  end

  // work word for the back end
  assign cmd_push         = accept & eff_run;
  assign cmd_flags.first  = in_restart;
  assign cmd_flags.last   = is_last;
  assign cmd_flags.negate = base_phase[PHASE_BITS-1];
  assign cmd_flags.mirror = base_phase[PHASE_BITS-2];
  assign cmd_index        = base_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  // tone state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      done_r    <= '0;
      running_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      done_r    <= done_nxt;
      running_r <= running_nxt;
    end
  end

  // step and length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= PHASE_BITS'(PHASE_STEP_RST);
      count_r <= COUNT_BITS'(SAMPLE_COUNT_RST);
    end else begin
      if (cfg_wr.step_we)  step_r  <= PHASE_BITS'(cfg_wdata[STEP_W-1:0]);
      if (cfg_wr.count_we) count_r <= COUNT_BITS'(cfg_wdata[CNT_W-1:0]);
    end
  end

endmodule

// File: rtl/dso_back.sv
// Back end: envelope recurrence, quarter-wave table read and sample scaling.
module dso_back import dso_pkg::*; #(
  parameter int TABLE_ADDR_BITS = DSO_TABLE_ADDR_BITS,
  parameter int SAMPLE_BITS     = DSO_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_wr_t                        cfg_wr,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  logic                           cmd_empty,
  input  cmd_flags_t                     cmd_flags,
  input  logic [TABLE_ADDR_BITS-1:0]     cmd_index,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH):0]     out_count,
  output logic                           res_push,
  output logic [SAMPLE_BITS-1:0]         res_sample,
  output logic                           res_last
);

  localparam int MAG_W     = SAMPLE_BITS - 1;
  localparam int ROM_DEPTH = (1 << TABLE_ADDR_BITS) + 1;
  localparam int RA_W      = TABLE_ADDR_BITS + 1;
  localparam int PROD_W    = MAG_W + ENV_W;
  localparam int RES_W     = PROD_W - ENV_FRAC + 1;
  localparam int OCC_W     = $clog2(OUT_DEPTH) + 2;
  localparam logic [RES_W-1:0] SMAX = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [RES_W-1:0] HALF = RES_W'(1 << (SAMPLE_BITS - 1));
  localparam logic [PROD_W:0]  RND  = (PROD_W+1)'((1 << ENV_FRAC) - 1);

  // quarter-wave table, built at elaboration
  logic [MAG_W-1:0] rom [ROM_DEPTH];
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    assign rom[g] = MAG_W'(sine_entry(g, TABLE_ADDR_BITS, SAMPLE_BITS));
  end

  logic [ENV_W-1:0]     decay_r;
  logic [ENV_W-1:0]     env_r, env_nxt;
  logic [ENV_W-1:0]     env_base;
  logic [2*ENV_W-1:0]   env_prod;
  logic [RA_W-1:0]      rom_addr;
  logic [OCC_W-1:0]     occupancy;

  logic                 s1_v_r, s1_neg_r, s1_last_r;
  logic [MAG_W-1:0]     rom_q_r;
  logic                 s2_v_r, s2_neg_r, s2_last_r;
  logic [PROD_W-1:0]    prod_r;

  logic [PROD_W:0]      rnd_sum;
  logic [RES_W-1:0]     mag_up;
  logic [RES_W-1:0]     mag_dn;

  // take a word only when the result queue has room for everything in flight
  assign occupancy = OCC_W'(out_count) + OCC_W'(s1_v_r) + OCC_W'(s2_v_r);
  assign cmd_pop   = ~cmd_empty & (occupancy < OCC_W'(OUT_DEPTH));

  // envelope: one decay step per sample, saturated
  always_comb begin
    env_base = cmd_flags.first ? ENV_ONE : env_r;
    env_prod = env_base * decay_r;
    if (env_prod[2*ENV_W-1]) env_nxt = ENV_MAX;
    else                     env_nxt = env_prod[2*ENV_W-2:ENV_FRAC];
  end

  // table address, mirrored in odd quadrants
  assign rom_addr = cmd_flags.mirror ? RA_W'(1 << TABLE_ADDR_BITS) - {1'b0, cmd_index}
                                     : {1'b0, cmd_index};

  // stage 1: envelope and table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r   <= ENV_ONE;
      decay_r <= DECAY_RST;
    end else begin
      if (cmd_pop)         env_r   <= env_nxt;
      if (cfg_wr.decay_we) decay_r <= cfg_wdata[DECAY_CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rom_q_r   <= rom[rom_addr];
      s1_neg_r  <= cmd_flags.negate;
      s1_last_r <= cmd_flags.last;
    end
  end

  // stage 2: scale magnitude by the envelope
  always_ff @(posedge clk) begin
    prod_r    <= rom_q_r * env_r;
    s2_neg_r  <= s1_neg_r;
    s2_last_r <= s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd_pop;
      s2_v_r <= s1_v_r;
    end
  end

  // floor of the signed product, then saturate
  always_comb begin
    rnd_sum = {1'b0, prod_r} + RND;
    mag_up  = rnd_sum[PROD_W:ENV_FRAC];
    mag_dn  = RES_W'(prod_r[PROD_W-1:ENV_FRAC]);
    if (s2_neg_r) begin
      if (mag_up > HALF) res_sample = HALF[SAMPLE_BITS-1:0];
      else               res_sample = -mag_up[SAMPLE_BITS-1:0];
    end else begin
      if (mag_dn > SMAX) res_sample = SMAX[SAMPLE_BITS-1:0];
      else               res_sample = mag_dn[SAMPLE_BITS-1:0];
    end
  end

  assign res_push = s2_v_r;
  assign res_last = s2_last_r;

endmodule

// File: rtl/decaying_sine_oscillator.sv
// Top level of the damped sine tone generator.
//
//   channel  ports                                  direction  word
//   tick     in_push, in_full, in_restart           in         restart flag
//   sample   out_pop, out_empty, out_sample, out_last  out     signed sample, end of tone
//   config   cfg_we, cfg_index, cfg_wdata           in         register write
//
// One tick is taken per cycle while the work queue has room; a sample passes through
// the work queue, the envelope/table stage and the scaling multiplier on its way to
// the result queue. The envelope recurrence is one 24x24 multiply per cycle, so
// samples stream back to back while the result queue has room. Reset is synchronous
// (rst_n low): the tone is idle, the phase and count are clear and the registers take
// their defaults. When the result queue has no room for one more sample beyond those
// in flight, the back end stops taking work, the work queue fills and in_full rises.
module decaying_sine_oscillator import dso_pkg::*; #(
  parameter int PHASE_BITS      = DSO_PHASE_BITS,
  parameter int TABLE_ADDR_BITS = DSO_TABLE_ADDR_BITS,
  parameter int SAMPLE_BITS     = DSO_SAMPLE_BITS,
  parameter int COUNT_BITS      = DSO_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_restart,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);

  localparam int CMD_W = $bits(cmd_flags_t) + TABLE_ADDR_BITS;
  localparam int OUT_W = SAMPLE_BITS + 1;

  cfg_wr_t                    cfg_wr;
  logic                       cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_flags_t                 f_flags, b_flags;
  logic [TABLE_ADDR_BITS-1:0] f_index, b_index;
  logic [CMD_W-1:0]           cmd_rdata;
  logic [$clog2(CMD_DEPTH):0] cmd_count;
  logic                       res_push, res_last;
  logic [SAMPLE_BITS-1:0]     res_sample;
  logic [OUT_W-1:0]           out_rdata;
  logic                       out_full;
  logic [$clog2(OUT_DEPTH):0] out_count;

  // register decode; unknown index is dropped
  assign cfg_wr.step_we  = cfg_we & (cfg_index == CFG_PHASE_STEP);
  assign cfg_wr.decay_we = cfg_we & (cfg_index == CFG_DECAY);
  assign cfg_wr.count_we = cfg_we & (cfg_index == CFG_COUNT);

  dso_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .cfg_wdata  (cfg_wdata),
    .in_push    (in_push),
    .in_restart (in_restart),
    .in_full    (in_full),
    .cmd_push   (cmd_push),
    .cmd_flags  (f_flags),
    .cmd_index  (f_index),
    .cmd_full   (cmd_full)
  );

  // work queue between front and back
  dso_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata ({f_flags, f_index}),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .full  (cmd_full),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  assign b_flags = cmd_rdata[CMD_W-1 -: $bits(cmd_flags_t)];
  assign b_index = cmd_rdata[TABLE_ADDR_BITS-1:0];

  dso_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .cfg_wdata  (cfg_wdata),
    .cmd_empty  (cmd_empty | (cmd_count == '0)),
    .cmd_flags  (b_flags),
    .cmd_index  (b_index),
    .cmd_pop    (cmd_pop),
    .out_count  (out_count),
    .res_push   (res_push),
    .res_sample (res_sample),
    .res_last   (res_last)
  );

  // result queue
  dso_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_last, res_sample}),
    .pop   (out_pop),
    .rdata (out_rdata),
    .full  (out_full),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_sample = out_rdata[SAMPLE_BITS-1:0];
  assign out_last   = out_rdata[OUT_W-1] & ~out_full | out_rdata[OUT_W-1] & out_full;

endmodule

// File: bench/decaying_sine_oscillator_tb.sv
// Self-checking bench for the damped sine tone generator: predicts every sample and checks it.
`timescale 1ns / 100ps

module decaying_sine_oscillator_tb import dso_pkg::*;;

  localparam int PH_W       = DSO_PHASE_BITS;
  localparam int TAB_W      = DSO_TABLE_ADDR_BITS;
  localparam int SMP_W      = DSO_SAMPLE_BITS;
  localparam int CNT_W      = DSO_COUNT_BITS;
  localparam int QTR_SIZE   = 1 << TAB_W;
  localparam int RAND_TICKS = 1200;
  localparam int DRAIN_CYC  = 24;
  localparam int DOG_LIMIT  = 500;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } tone_word_t;

  // Tone predictor plus the queue of samples still owed by the block
  class tone_scoreboard;
    int               wave [QTR_SIZE+1];
    logic [PH_W-1:0]  step;
    logic [ENV_W-1:0] decay;
    logic [CNT_W-1:0] tone_len;
    logic [PH_W-1:0]  phase;
    logic [ENV_W-1:0] env;
    logic [CNT_W-1:0] done_cnt;
    bit               running;
    tone_word_t       owed [$];
    int               errors;

    function new();
      for (int i = 0; i <= QTR_SIZE; i++) wave[i] = wave_point(i);
      step     = PHASE_STEP_RST[PH_W-1:0];
      decay    = DECAY_RST;
      tone_len = SAMPLE_COUNT_RST[CNT_W-1:0];
      phase    = '0;
      env      = ENV_ONE;
      done_cnt = '0;
      running  = 1'b0;
      errors   = 0;
    endfunction

    // Quarter-wave magnitude at point i, nine-term series in Q30
    function int wave_point(int unsigned i);
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned term;
      longint unsigned v;
      longint unsigned top;
      longint          acc;
      ang  = (longint'(i) * HALF_PI_Q30) >> TAB_W;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      top  = (64'd1 << (SMP_W - 1)) - 64'd1;
      for (int k = 1; k <= 9; k++) begin
        term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - longint'(term);
        else            acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = ((unsigned'(acc) << (SMP_W - 1)) + (64'd1 << 29)) >> 30;
      if (v > top) v = top;
      return int'(v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_PHASE_STEP: step = d[PH_W-1:0];
        CFG_DECAY:      decay = d[ENV_W-1:0];
        CFG_COUNT:      tone_len = d[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // One accepted tick: advance the tone and queue the sample it yields, if any
    function void note_tick(logic restart);
      logic [2*ENV_W-1:0] grown;
      logic [1:0]         quad;
      logic [TAB_W-1:0]   idx;
      int                 sine;
      longint             prod;
      tone_word_t         w;
      if (restart) begin
        phase    = '0;
        env      = ENV_ONE;
        done_cnt = '0;
        running  = (tone_len != 0);
      end
      if (!running) return;
      grown = ({{ENV_W{1'b0}}, env} * {{ENV_W{1'b0}}, decay}) >> ENV_FRAC;
      env   = (grown > {{ENV_W{1'b0}}, ENV_MAX}) ? ENV_MAX : grown[ENV_W-1:0];
      quad  = phase[PH_W-1 -: 2];
      idx   = phase[PH_W-3 -: TAB_W];
      sine  = quad[0] ? wave[QTR_SIZE - idx] : wave[idx];
      if (quad[1]) sine = -sine;
      // floor of the scaled product, then clip to the sample range
      prod = (longint'(sine) * longint'(env)) >>> ENV_FRAC;
      if (prod > longint'((1 << (SMP_W - 1)) - 1)) prod = longint'((1 << (SMP_W - 1)) - 1);
      if (prod < -longint'(1 << (SMP_W - 1)))      prod = -longint'(1 << (SMP_W - 1));
      phase    = phase + step;
      done_cnt = done_cnt + 1'b1;
      w.sample = prod[SMP_W-1:0];
      w.last   = (done_cnt >= tone_len);
      if (w.last) running = 1'b0;
      owed.push_back(w);
    endfunction

    function void check_sample(logic signed [SMP_W-1:0] s, logic l);
      tone_word_t w;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word: sample %0d last %0b", $realtime, s, l);
        return;
      end
      w = owed.pop_front();
      if (w.sample !== s || w.last !== l) begin
        errors++;
        if (errors <= 10)
          $display("%0t: word mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                   $realtime, w.sample, w.last, s, l);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_push;
  logic                    in_full;
  logic                    in_restart;
  logic                    out_pop;
  logic                    out_empty;
  logic signed [SMP_W-1:0] out_sample;
  logic                    out_last;

  tone_scoreboard sb;
  bit             in_burst;
  bit             out_burst;
  int             quiet;

  decaying_sine_oscillator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_restart (in_restart),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= DOG_LIMIT) begin
      $display("decaying_sine_oscillator_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Register write; cfg_we drops again before the task returns, so strobes stay apart
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] stp, logic [CFG_DATA_W-1:0] dcy,
                           logic [CFG_DATA_W-1:0] cnt);
    write_reg(CFG_PHASE_STEP, stp);
    write_reg(CFG_DECAY, dcy);
    write_reg(CFG_COUNT, cnt);
  endtask

  // Push one tick word; push stays high so back-to-back words need no gap
  task automatic send_tick(logic restart);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_full);
    sb.note_tick(restart);
  endtask

  // Drop push, wait for every owed sample, then let the pipe drain
  task automatic settle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic random_config();
    logic [PH_W-1:0]  stp;
    logic [ENV_W-1:0] dcy;
    logic [CNT_W-1:0] cnt;
    case ($urandom_range(0, 5))
      0:       stp = '0;
      1:       stp = 32'h8000_0000;
      2:       stp = $urandom_range(1, 32'h0100_0000);
      default: stp = $urandom_range(0, 32'h8000_0000);
    endcase
    case ($urandom_range(0, 7))
      0:       dcy = ENV_ONE;
      1:       dcy = ENV_W'($urandom_range(0, ENV_ONE));
      2:       dcy = ENV_W'($urandom_range(ENV_ONE + 1, ENV_MAX));
      3:       dcy = '0;
      default: dcy = ENV_ONE - ENV_W'($urandom_range(0, 40000));
    endcase
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1:       cnt = CNT_W'($urandom_range(41, 400));
      2:       cnt = '1;
      default: cnt = CNT_W'($urandom_range(1, 40));
    endcase
    if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, $urandom);
    // upper data bits above a 24-bit register are don't-care
    configure(stp, {8'($urandom_range(0, 255)), dcy}, {8'($urandom_range(0, 255)), cnt});
  endtask

  // Sample sink: random stall before each pop, burst phases pop every cycle while samples wait
  initial begin : sample_sink
    int stall;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_sample(out_sample, out_last);
    end
  end

  initial begin : stimulus
    int  tone_ticks;
    int  n;
    bit  restart;
    sb         = new();
    tone_ticks = 0;
    in_burst   = 1'b0;
    out_burst  = 1'b0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_PHASE_STEP;
    cfg_wdata  <= '0;
    in_push    <= 1'b0;
    in_restart <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks before any tone, then a default tone restarted while running
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    // Quarter-turn steps at unit envelope: zero crossings and full-scale peaks
    configure(32'h4000_0000, 32'(ENV_ONE), 5);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    settle();

    // Decay above one on the longest tone: envelope and sample both clip
    configure(32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    settle();

    // Length lowered under the running count: next sample ends the tone
    write_reg(CFG_COUNT, 2);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // Zero-length tone, ignored register index, zero decay, half-turn step
    configure(32'h8000_0000, 0, 0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_tick(1'b1);
    settle();
    write_reg(CFG_COUNT, 3);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    settle();

    // Random phases: new settings, mostly well-formed tones, some idle noise
    while (tone_ticks < RAND_TICKS) begin
      random_config();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 60);
      for (int i = 0; i < n; i++) begin
        if (!sb.running) restart = ($urandom_range(0, 3) != 0);
        else             restart = ($urandom_range(0, 39) == 0);
        if (i == 0 && $urandom_range(0, 3) != 0) restart = 1'b1;
        if (restart || sb.running) tone_ticks++;
        send_tick(restart);
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("decaying_sine_oscillator_tb: PASS");
    end else begin
      $display("decaying_sine_oscillator_tb: FAIL");
    end
    $finish;
  end

endmodule
